/* rtl/psc_pkg.sv */
// Shared types, constants and the sine table builder for the polar scan converter.
// No dependencies.
package psc_pkg;

	localparam int TABLE_BITS_DEF = 12;
	localparam int ANGLE_W        = 16;
	localparam int RANGE_W        = 20;
	localparam int POINT_W        = 21;
	localparam int TRIG_W         = 15;   // magnitude of a table entry, up to 32767
	localparam int FRAC_BITS      = 15;
	localparam int CFG_IDX_W      = 1;
	localparam int CFG_DATA_W     = 16;
	localparam real TWO_PI        = 6.283185307179586476925;
	localparam real TRIG_SCALE    = 32767.0;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_START_ANGLE = 1'b0,
		REG_ANGLE_STEP  = 1'b1
	} cfg_reg_t;

	// Quadrant signs that travel alongside the table lookup
	typedef struct packed {
		logic sin_neg;
		logic cos_neg;
	} trig_sign_t;

	// round(32767 * sin(2*pi*k / 2^tb)) for k in the first quadrant, so never negative
	function automatic int sine_entry(int k, int tb);
		real x;
		real v;
		x = TWO_PI * real'(k) * (2.0 ** (-tb));
		v = TRIG_SCALE * $sin(x);
		return $rtoi(v + 0.5);
	endfunction

endpackage

/* rtl/psc_if.sv */
// Valid/ready channel interfaces for scan beats in and point beats out.
// Depends on psc_pkg.
interface psc_scan_if
	import psc_pkg::*;
();
	logic               valid;
	logic               ready;
	logic [RANGE_W-1:0] range_value;
	logic               scan_start;

	modport source (output valid, output range_value, output scan_start, input ready);
	modport sink   (input valid, input range_value, input scan_start, output ready);
endinterface

interface psc_point_if
	import psc_pkg::*;
();
	logic                      valid;
	logic                      ready;
	logic signed [POINT_W-1:0] point_x;
	logic signed [POINT_W-1:0] point_y;

	modport source (output valid, output point_x, output point_y, input ready);
	modport sink   (input valid, input point_x, input point_y, output ready);
endinterface

/* rtl/psc_angle.sv */
// Configuration registers, ray angle register and quadrant folding of the table index.
// Depends on psc_pkg.
module psc_angle
	import psc_pkg::*;
#(
	parameter int TABLE_BITS = TABLE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  cfg_reg_t              cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  accept,
	input  logic                  scan_start,
	output logic [TABLE_BITS-2:0] sin_addr,
	output logic [TABLE_BITS-2:0] cos_addr,
	output trig_sign_t            sign,
	output logic [ANGLE_W-1:0]    ray_angle
);
	localparam int QUART_W = TABLE_BITS - 2;
	localparam logic [TABLE_BITS-2:0] QUART = (TABLE_BITS-1)'(1) << QUART_W;

	logic [ANGLE_W-1:0]    start_angle_q;
	logic [ANGLE_W-1:0]    angle_step_q;
	logic [ANGLE_W-1:0]    ray_angle_q;
	logic [ANGLE_W-1:0]    angle_next;
	logic [TABLE_BITS-1:0] k_sin;
	logic [TABLE_BITS-1:0] k_cos;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_angle_q <= '0;
			angle_step_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_START_ANGLE: start_angle_q <= cfg_data[ANGLE_W-1:0];
				REG_ANGLE_STEP:  angle_step_q  <= cfg_data[ANGLE_W-1:0];
			endcase
		end
	end

	assign angle_next = scan_start ? start_angle_q : ANGLE_W'(ray_angle_q + angle_step_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			ray_angle_q <= '0;
		else if (accept)
			ray_angle_q <= angle_next;
	end

	assign ray_angle = ray_angle_q;

	// cosine is the sine a quarter turn on
	assign k_sin = angle_next[ANGLE_W-1 -: TABLE_BITS];
	assign k_cos = TABLE_BITS'(k_sin + (TABLE_BITS'(1) << QUART_W));

	function automatic logic [TABLE_BITS-2:0] fold(input logic [TABLE_BITS-1:0] k);
		logic [TABLE_BITS-2:0] r;
		r = {1'b0, k[QUART_W-1:0]};
		return k[QUART_W] ? (TABLE_BITS-1)'(QUART - r) : r;
	endfunction

	assign sin_addr     = fold(k_sin);
	assign cos_addr     = fold(k_cos);
	assign sign.sin_neg = k_sin[TABLE_BITS-1];
	assign sign.cos_neg = k_cos[TABLE_BITS-1];

endmodule

/* rtl/psc_sine_rom.sv */
// Quarter-wave sine ROM, two read ports with registered data.
// Depends on psc_pkg.
module psc_sine_rom
	import psc_pkg::*;
#(
	parameter int TABLE_BITS = TABLE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  en,
	input  logic [TABLE_BITS-2:0] sin_addr,
	input  logic [TABLE_BITS-2:0] cos_addr,
	output logic [TRIG_W-1:0]     sin_mag_s1,
	output logic [TRIG_W-1:0]     cos_mag_s1
);
	localparam int DEPTH = (1 << (TABLE_BITS - 2)) + 1;

	typedef logic [TRIG_W-1:0] rom_t [DEPTH];

	function automatic rom_t build_rom();
		rom_t t;
		for (int i = 0; i < DEPTH; i++)
			t[i] = TRIG_W'(sine_entry(i, TABLE_BITS));
		return t;
	endfunction

	localparam rom_t ROM = build_rom();

	always_ff @(posedge clk) begin
		if (en) begin
			sin_mag_s1 <= ROM[sin_addr];
			cos_mag_s1 <= ROM[cos_addr];
		end
	end

endmodule

/* rtl/psc_scale.sv */
// Range times signed sine/cosine, floor shift by 15, into the output register.
// Depends on psc_pkg.
module psc_scale
	import psc_pkg::*;
(
	input  logic                       clk,
	input  logic                       en,
	input  logic [RANGE_W-1:0]         range_s1,
	input  logic [TRIG_W-1:0]          sin_mag_s1,
	input  logic [TRIG_W-1:0]          cos_mag_s1,
	input  trig_sign_t                 sign_s1,
	output logic signed [POINT_W-1:0]  point_x_s2,
	output logic signed [POINT_W-1:0]  point_y_s2
);
	localparam int PROD_W = RANGE_W + 1 + TRIG_W + 1;

	logic signed [TRIG_W:0]   sin_v;
	logic signed [TRIG_W:0]   cos_v;
	logic signed [RANGE_W:0]  range_v;
	logic signed [PROD_W-1:0] prod_x;
	logic signed [PROD_W-1:0] prod_y;

	assign sin_v   = sign_s1.sin_neg ? -$signed({1'b0, sin_mag_s1}) : $signed({1'b0, sin_mag_s1});
	assign cos_v   = sign_s1.cos_neg ? -$signed({1'b0, cos_mag_s1}) : $signed({1'b0, cos_mag_s1});
	assign range_v = $signed({1'b0, range_s1});
	assign prod_x  = PROD_W'(range_v * cos_v);
	assign prod_y  = PROD_W'(range_v * sin_v);

	// dropping the low bits of a two's complement product floors it
	always_ff @(posedge clk) begin
		if (en) begin
			point_x_s2 <= prod_x[FRAC_BITS +: POINT_W];
			point_y_s2 <= prod_y[FRAC_BITS +: POINT_W];
		end
	end

endmodule

/* rtl/polar_scan_to_cartesian.sv */
// Top level of the polar scan converter: angle tracking, sine ROM, scaling, flow control.
// Depends on psc_pkg, psc_if, psc_angle, psc_sine_rom, psc_scale.
//
//  channel     dir  beat                          handshake
//  scan_in     in   range_value, scan_start       valid/ready
//  point_out   out  point_x, point_y              valid/ready
//  cfg_*       in   cfg_index, cfg_data           cfg_we, no back-pressure
//
// One beat per cycle sustained while point_out is ready.
// Stage one: angle update and the two ROM reads; stage two: the two multiplies.
// Stalls on point_out hold both stages and, while stage one holds a beat, drop scan_in.ready in the same cycle.
// Reset clears the config registers, the ray angle and the stage valids; no clearing pass.
module polar_scan_to_cartesian
	import psc_pkg::*;
#(
	parameter int TABLE_BITS = TABLE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	psc_scan_if.sink              scan_in,
	psc_point_if.source           point_out
);
	logic                  valid_s1;
	logic                  valid_s2;
	logic                  adv_s1;
	logic                  accept;
	logic [TABLE_BITS-2:0] sin_addr;
	logic [TABLE_BITS-2:0] cos_addr;
	trig_sign_t            sign;
	trig_sign_t            sign_s1;
	logic [RANGE_W-1:0]    range_s1;
	logic [TRIG_W-1:0]     sin_mag_s1;
	logic [TRIG_W-1:0]     cos_mag_s1;
	logic [ANGLE_W-1:0]    ray_angle;
	logic [ANGLE_W-1:0]    start_angle_shadow_q;

	assign adv_s1        = !valid_s2 || point_out.ready;
	assign scan_in.ready = !valid_s1 || adv_s1;
	assign accept        = scan_in.valid && scan_in.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (scan_in.ready)
				valid_s1 <= scan_in.valid;
			if (adv_s1)
				valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			range_s1 <= scan_in.range_value;
			sign_s1  <= sign;
		end
	end

	psc_angle #(.TABLE_BITS(TABLE_BITS)) u_angle (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_reg_t'(cfg_index)),
		.cfg_data   (cfg_data),
		.accept     (accept),
		.scan_start (scan_in.scan_start),
		.sin_addr   (sin_addr),
		.cos_addr   (cos_addr),
		.sign       (sign),
		.ray_angle  (ray_angle)
	);

	psc_sine_rom #(.TABLE_BITS(TABLE_BITS)) u_rom (
		.clk        (clk),
		.en         (accept),
		.sin_addr   (sin_addr),
		.cos_addr   (cos_addr),
		.sin_mag_s1 (sin_mag_s1),
		.cos_mag_s1 (cos_mag_s1)
	);

	psc_scale u_scale (
		.clk        (clk),
		.en         (valid_s1 && adv_s1),
		.range_s1   (range_s1),
		.sin_mag_s1 (sin_mag_s1),
		.cos_mag_s1 (cos_mag_s1),
		.sign_s1    (sign_s1),
		.point_x_s2 (point_out.point_x),
		.point_y_s2 (point_out.point_y)
	);

	assign point_out.valid = valid_s2;

	// copy of the start angle, kept for checking the reload
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			start_angle_shadow_q <= '0;
		else if (cfg_we && cfg_reg_t'(cfg_index) == REG_START_ANGLE)
			start_angle_shadow_q <= cfg_data[ANGLE_W-1:0];
	end

`ifndef SYNTHESIS
	a_start_reload: assert property (@(posedge clk) disable iff (!arst_n)
		accept && scan_in.scan_start |=> ray_angle == $past(start_angle_shadow_q))
		else $error("ray angle not reloaded on scan start");

	a_rom_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv_s1 |=> $stable(sin_mag_s1) && $stable(cos_mag_s1))
		else $error("stage one lookup changed while stalled");

	a_out_from_s1: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(valid_s2) |-> $past(valid_s1))
		else $error("point beat without a stage one beat");

	a_angle_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |=> $stable(ray_angle))
		else $error("ray angle moved without an accepted beat");
`endif

endmodule
